// ===== sv/salc_pkg.sv =====
// Shared types and constants for the set-associative LRU cache model.
// Used by salc_ctrl, salc_dp and set_assoc_lru_cache_sim; no dependencies.
`default_nettype none
package salc_pkg;

  // Fixed field widths
  localparam int ADDR_W      = 64;
  localparam int OP_W        = 2;
  localparam int TAG_W       = 62;
  localparam int STAMP_W     = 32;
  localparam int COUNT_W     = 32;
  localparam int SET_BITS_W  = 4;
  localparam int BLK_BITS_W  = 6;
  localparam int WAYS_W      = 4;
  localparam int WCNT_W      = 5;
  localparam int SHIFT_W     = 7;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int OUT_DATA_W  = 104;

  // Access kinds; the unused code behaves as a load
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WAYS_USED  = 2'd2;

  // Configuration reset values
  localparam logic [SET_BITS_W-1:0] SET_BITS_RST   = 4'd4;
  localparam logic [BLK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;
  localparam logic [WAYS_W-1:0]     WAYS_USED_RST  = 4'd1;

  // One cache line as kept in the set memory
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // register the accepted address
    logic lookup;   // decode address, read the set row
    logic commit;   // update the set row, counters and the result register
    logic last;     // result being committed is the final one of its item
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // result register can take a result this cycle
  } dp_stat_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_READ   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] x);
    sat_inc = (x == '1) ? x : x + COUNT_W'(1);
  endfunction

endpackage
`default_nettype wire

// ===== sv/salc_ctrl.sv =====
// Sequencer for the cache model: accept, set read, set update per access.
// Depends on salc_pkg for the command, status and state types.
`default_nettype none
module salc_ctrl (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [salc_pkg::OP_W-1:0]           in_tuser,
  output salc_pkg::dp_cmd_t                   cmd,
  input  salc_pkg::dp_stat_t                  stat
);
  import salc_pkg::*;

  state_t          state_r, state_nxt;
  logic [OP_W-1:0] op_r;
  logic            second_r, second_nxt;
  logic            accept;
  logic            two_pass;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;
  // A modify item makes a second access on its first pass only
  assign two_pass  = (op_r == OP_MODIFY) & ~second_r;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    second_nxt  = second_r;
    cmd.capture = 1'b0;
    cmd.lookup  = 1'b0;
    cmd.commit  = 1'b0;
    cmd.last    = ~two_pass;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          second_nxt  = 1'b0;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_COMMIT;
      end
      S_COMMIT: begin
        // Hold until the result register is free
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          if (two_pass) begin
            second_nxt = 1'b1;
            state_nxt  = S_READ;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

  // Access kind of the item in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_tuser;
    end
  end

endmodule
`default_nettype wire

// ===== sv/salc_dp.sv =====
// Datapath: configuration, address split, set memory, hit and victim
// selection, counters and result register. Depends on salc_pkg.
`default_nettype none
module salc_dp #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int STAMP_BITS   = 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire  [salc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire  [salc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire  [salc_pkg::ADDR_W-1:0]         in_tdata,
  input  salc_pkg::dp_cmd_t                   cmd,
  output salc_pkg::dp_stat_t                  stat,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [salc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);
  import salc_pkg::*;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WAY_IW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TREE_N   = 1 << $clog2(MAX_WAYS);

  typedef line_t [MAX_WAYS-1:0] row_t;

  // Configuration registers
  logic [SET_BITS_W-1:0] set_bits_r;
  logic [BLK_BITS_W-1:0] block_bits_r;
  logic [WAYS_W-1:0]     ways_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= SET_BITS_RST;
      block_bits_r <= BLOCK_BITS_RST;
      ways_used_r  <= WAYS_USED_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SET_BITS:   set_bits_r   <= cfg_wdata[SET_BITS_W-1:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_wdata[BLK_BITS_W-1:0];
        CFG_WAYS_USED:  ways_used_r  <= cfg_wdata[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp set bits and ways to what the storage holds
  logic [SET_BITS_W-1:0] sb_eff;
  logic [WCNT_W-1:0]     ways_eff;

  always_comb begin
    sb_eff = (32'(set_bits_r) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS) : set_bits_r;
    if (ways_used_r == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (32'(ways_used_r) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_used_r);
    end
  end

  // Address of the item in flight
  logic [ADDR_W-1:0] addr_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r <= in_tdata;
    end
  end

  // Split the address into set index and tag
  logic [ADDR_W-1:0]       set_shift;
  logic [MAX_SET_BITS:0]   set_one;
  logic [MAX_SET_BITS-1:0] set_mask;
  logic [MAX_SET_BITS-1:0] set_idx;
  logic [SHIFT_W-1:0]      tag_sh;
  logic [ADDR_W-1:0]       tag_shift;
  logic [TAG_W-1:0]        tag_idx;

  always_comb begin
    set_shift = addr_r >> block_bits_r;
    set_one   = (MAX_SET_BITS+1)'(1) << sb_eff;
    set_mask  = MAX_SET_BITS'(set_one - (MAX_SET_BITS+1)'(1));
    set_idx   = set_shift[MAX_SET_BITS-1:0] & set_mask;
    tag_sh    = SHIFT_W'(block_bits_r) + SHIFT_W'(sb_eff);
    tag_shift = addr_r >> tag_sh;
    // A shift of 64 or more leaves no tag bits
    tag_idx   = tag_sh[SHIFT_W-1] ? '0 : tag_shift[TAG_W-1:0];
  end

  // Set memory, one row of all ways per set; row marks stand for valid rows
  row_t                    mem [NUM_SETS];
  logic [NUM_SETS-1:0]     row_init_r;
  row_t                    row_q_r;
  logic                    init_q_r;
  logic [MAX_SET_BITS-1:0] set_r;
  logic [TAG_W-1:0]        tag_r;
  row_t                    row_w;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      row_q_r <= mem[set_idx];
      set_r   <= set_idx;
      tag_r   <= tag_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[set_r] <= row_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
      init_q_r   <= 1'b0;
    end else begin
      if (cmd.lookup) begin
        init_q_r <= row_init_r[set_idx];
      end
      if (cmd.commit) begin
        row_init_r[set_r] <= 1'b1;
      end
    end
  end

  // Per-way enable, valid and tag match
  logic [MAX_WAYS-1:0] way_en;
  logic [MAX_WAYS-1:0] way_vld;
  logic [MAX_WAYS-1:0] way_match;
  logic                hit;
  logic                any_free;
  logic [WAY_IW-1:0]   hit_way;
  logic [WAY_IW-1:0]   free_way;

  always_comb begin
    hit      = 1'b0;
    any_free = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_en[w]    = (WCNT_W'(w) < ways_eff);
      way_vld[w]   = init_q_r & row_q_r[w].valid;
      way_match[w] = way_en[w] & way_vld[w] & (row_q_r[w].tag == tag_r);
    end
    // Lowest numbered way wins: scan from the top down
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (way_match[w]) begin
        hit     = 1'b1;
        hit_way = WAY_IW'(w);
      end
      if (way_en[w] & ~way_vld[w]) begin
        any_free = 1'b1;
        free_way = WAY_IW'(w);
      end
    end
  end

  // LRU victim: tournament over stamps, ties go to the lower way
  logic               t_en    [1:2*TREE_N-1];
  logic [STAMP_W-1:0] t_stamp [1:2*TREE_N-1];
  logic [WAY_IW-1:0]  t_idx   [1:2*TREE_N-1];
  logic               take_left;

  always_comb begin
    take_left = 1'b0;
    for (int i = 0; i < TREE_N; i++) begin
      t_en[TREE_N+i]    = 1'b0;
      t_stamp[TREE_N+i] = '1;
      t_idx[TREE_N+i]   = WAY_IW'(i);
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      t_en[TREE_N+i]    = way_en[i];
      t_stamp[TREE_N+i] = row_q_r[i].stamp;
    end
    for (int n = TREE_N - 1; n >= 1; n--) begin
      take_left  = t_en[2*n] & (~t_en[2*n+1] | (t_stamp[2*n] <= t_stamp[2*n+1]));
      t_en[n]    = t_en[2*n] | t_en[2*n+1];
      t_stamp[n] = take_left ? t_stamp[2*n] : t_stamp[2*n+1];
      t_idx[n]   = take_left ? t_idx[2*n]   : t_idx[2*n+1];
    end
  end

  // Stamp counter, totals and flags
  logic [STAMP_BITS-1:0] use_r;
  logic [STAMP_BITS-1:0] use_nxt;
  logic [COUNT_W-1:0]    hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [COUNT_W-1:0]    hit_cnt_nxt, miss_cnt_nxt, evict_cnt_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  evict;
  logic [WAY_IW-1:0]     way_sel;

  always_comb begin
    use_nxt       = use_r + STAMP_BITS'(1);
    ovf_nxt       = ovf_r | (use_nxt == '0);
    evict         = ~hit & ~any_free;
    hit_cnt_nxt   = hit   ? sat_inc(hit_cnt_r)   : hit_cnt_r;
    miss_cnt_nxt  = ~hit  ? sat_inc(miss_cnt_r)  : miss_cnt_r;
    evict_cnt_nxt = evict ? sat_inc(evict_cnt_r) : evict_cnt_r;
    priority if (hit) begin
      way_sel = hit_way;
    end else if (any_free) begin
      way_sel = free_way;
    end else begin
      way_sel = t_idx[1];
    end
  end

  // Updated row: drop stale valid bits, refresh the touched line
  always_comb begin
    row_w = row_q_r;
    for (int w = 0; w < MAX_WAYS; w++) begin
      row_w[w].valid = way_vld[w];
      if (WAY_IW'(w) == way_sel) begin
        row_w[w].valid = 1'b1;
        row_w[w].tag   = tag_r;
        row_w[w].stamp = STAMP_W'(use_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r       <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      ovf_r       <= 1'b0;
    end else if (cmd.commit) begin
      use_r       <= use_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // Result register; frees when the result transfer completes
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  assign stat.out_free = ~out_valid_r | out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign out_tlast     = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {4'b0000, ovf_nxt, evict_cnt_nxt, miss_cnt_nxt, hit_cnt_nxt,
                     evict, ~hit, hit};
      out_last_r <= cmd.last;
    end
  end

endmodule
`default_nettype wire

// ===== sv/set_assoc_lru_cache_sim.sv =====
// Top level of the set-associative LRU cache model: controller plus datapath.
// Depends on salc_pkg, salc_ctrl and salc_dp.
//
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    tdata: address[63:0]; tuser: op[1:0]
// out_     out  out_tvalid/out_tready  tdata: see port; tlast: last result
// cfg_     in   cfg_we                 cfg_addr: register index; cfg_wdata
//
// Each access after the item is accepted first splits the address and reads
// the set row (S_READ), then updates the row in the single-port set memory
// (S_COMMIT). A load or store item makes one access, a modify item two.
// Reset is synchronous and clears the per-set row marks at once; no sweep.
// While the result register holds an untaken result the update waits.
`default_nettype none
module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int STAMP_BITS   = 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [salc_pkg::ADDR_W-1:0]         in_tdata,   // address[63:0]
  input  wire  [salc_pkg::OP_W-1:0]           in_tuser,   // op[1:0]
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // hit[0], miss[1], eviction[2], hit_total[34:3], miss_total[66:35],
  // eviction_total[98:67], stamp_overflow[99], zero[103:100]
  output logic [salc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  input  wire                                 cfg_we,
  input  wire  [salc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire  [salc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import salc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

  salc_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .STAMP_BITS   (STAMP_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Every result is either a hit or a miss
  a_hit_xor_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] != out_tdata[1]))
    else $error("result is not exactly one of hit and miss");

  // An eviction only happens on a miss
  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2]) |-> out_tdata[1])
    else $error("eviction without miss");

  // An update never overwrites a result that has not been taken
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> stat.out_free)
    else $error("update while result register is busy");

  // No new item while a set access is in progress
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.lookup || cmd.commit) |-> !in_tready)
    else $error("input ready during a set access");

endmodule
`default_nettype wire
